### rtl/core/assert_macros.svh
// Assertion macros included by the decoder core; clk and rst_n are taken from the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/bytrun_pkg.sv
// Shared widths and constants of the ByteRun1 planar-to-chunky decoder.
package bytrun_pkg;

    // Field widths of the input and result beats.
    localparam int DataW    = 8;
    localparam int RowW     = 16;
    localparam int ColW     = 6;
    localparam int PixW     = 64;
    localparam int CntW     = 4;
    localparam int WidthW   = 10;

    // Column counter holds every column index and the column count itself.
    localparam int ColCntW  = 7;

    // Image limits.
    localparam int MaxWidthDef = 512;
    localparam int MaxPlanes   = 8;

    // ByteRun1 control codes and header layout.
    localparam logic [8:0] RunBase    = 9'd257;
    localparam logic [7:0] CtlRowEnd  = 8'd128;
    localparam logic [3:0] HeaderLast = 4'(6 + 6 - 1);
    localparam logic [3:0] HposWidthLo  = 4'd1;
    localparam logic [3:0] HposHeightLo = 4'd3;
    localparam logic [3:0] HposDepthLo  = 4'd5;
    localparam int         ColRound   = 7;

endpackage

### rtl/core/bytrun_in_if.sv
// Input channel of the decoder: one header or compressed byte per beat.
interface bytrun_in_if;
    logic                             valid;
    logic                             ready;
    logic [bytrun_pkg::DataW-1:0]     data_byte;
    logic                             first_of_image;

    modport source (output valid, data_byte, first_of_image, input ready);
    modport sink   (input valid, data_byte, first_of_image, output ready);
endinterface

### rtl/core/bytrun_out_if.sv
// Result channel of the decoder: one group of eight chunky pixels or an error per beat.
interface bytrun_out_if;
    logic                              valid;
    logic                              ready;
    logic                              status;
    logic [bytrun_pkg::RowW-1:0]       row_index;
    logic [bytrun_pkg::ColW-1:0]       byte_column;
    logic [bytrun_pkg::PixW-1:0]       pixels;
    logic [bytrun_pkg::CntW-1:0]       pixel_count;
    logic                              row_end;
    logic                              image_end;
    logic [bytrun_pkg::WidthW-1:0]     image_width;
    logic                              last;

    modport source (output valid, status, row_index, byte_column, pixels, pixel_count,
                    row_end, image_end, image_width, last, input ready);
    modport sink   (input valid, status, row_index, byte_column, pixels, pixel_count,
                    row_end, image_end, image_width, last, output ready);
endinterface

### rtl/core/bytrun_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bytrun_ram #(
    parameter int Width = 8,
    parameter int Depth = 64
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr,
    input  logic [Width-1:0]                      wdata,
    input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr,
    output logic [Width-1:0]                      rdata
);

    logic [Width-1:0] mem [Depth];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/byterun1_planar_to_chunky_decoder_core.sv
// Top level of the ByteRun1 planar-to-chunky decoder: header parser, row sequencer, merge unit.
//
// Usage:
//   stream carries one byte per beat. A beat with first_of_image set is header
//   byte 0 of a new image; the 12-byte header gives width, height and depth,
//   then the ByteRun1 stream follows, row by row and plane by plane.
//   result carries one beat per byte column of a finished row (eight chunky
//   pixels, leftmost in the top byte) or a single error beat when the header
//   is rejected. last marks the final beat caused by one input byte.
// Sequencing:
//   Header, control and literal bytes are each handled as they are taken. A run
//   byte is written by the fill into each column it covers, one at a time, since
//   the row-byte RAM has a single write port. The byte that ends a plane row
//   starts the merge pass, which reads the row-byte RAM and the accumulator RAM
//   once per column; on the last plane each column also leaves as a result.
//   stream.ready is low during a run fill, a merge pass or an error beat.
// Reset and stall:
//   Reset returns to header parsing with every row byte reading as zero.
//   One output register holds the pending result beat; while result.ready stays low the
//   merge pass of the last plane waits on that column and no input is taken.
module byterun1_planar_to_chunky_decoder_core #(
    parameter int MAX_WIDTH = bytrun_pkg::MaxWidthDef
) (
    input  logic              clk,
    input  logic              rst_n,
    bytrun_in_if.sink         stream,
    bytrun_out_if.source      result
);

`include "assert_macros.svh"

    localparam int Cols  = (MAX_WIDTH + bytrun_pkg::ColRound) / 8;
    localparam int AddrW = (Cols > 1) ? $clog2(Cols) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FILL,
        S_MERGE_RD,
        S_MERGE_OP,
        S_ERR
    } state_t;

    typedef enum logic [2:0] {
        P_HEADER,
        P_CONTROL,
        P_LITERAL,
        P_RUN,
        P_DONE,
        P_ERROR
    } phase_t;

    // Spread one plane byte into bit "pl" of eight chunky pixels.
    function automatic logic [bytrun_pkg::PixW-1:0] spread_plane(
        input logic [7:0] b,
        input logic [2:0] pl
    );
        logic [bytrun_pkg::PixW-1:0] r;
        r = '0;
        for (int i = 0; i < 8; i++)
        begin
            r[8 * (7 - i) + int'(pl)] = b[7 - i];
        end
        return r;
    endfunction

    // Keep only the leading cnt pixels of a group.
    function automatic logic [bytrun_pkg::PixW-1:0] pixel_mask(
        input logic [bytrun_pkg::CntW-1:0] cnt
    );
        logic [bytrun_pkg::PixW-1:0] m;
        m = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (bytrun_pkg::CntW'(i) < cnt)
            begin
                m[8 * (7 - i) +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

    // Sequencer and decoder registers.
    state_t                               state_reg, state_next;
    phase_t                               phase_reg, phase_next;
    logic [3:0]                           header_pos_reg, header_pos_next;
    logic [7:0]                           header_high_reg, header_high_next;
    logic [bytrun_pkg::WidthW-1:0]        width_reg, width_next;
    logic [bytrun_pkg::RowW-1:0]          height_reg, height_next;
    logic [3:0]                           plane_count_reg, plane_count_next;
    logic [bytrun_pkg::RowW-1:0]          row_reg, row_next;
    logic [2:0]                           plane_reg, plane_next;
    logic [bytrun_pkg::ColCntW-1:0]       col_reg, col_next;
    logic [7:0]                           lit_left_reg, lit_left_next;
    logic [7:0]                           run_left_reg, run_left_next;
    logic [7:0]                           fill_byte_reg, fill_byte_next;
    logic [Cols-1:0]                      row_valid_reg, row_valid_next;
    logic                                 rd_valid_reg;

    // Output register.
    logic                                 out_valid_reg, out_valid_next;
    logic                                 out_status_reg, out_status_next;
    logic [bytrun_pkg::RowW-1:0]          out_row_reg, out_row_next;
    logic [bytrun_pkg::ColW-1:0]          out_col_reg, out_col_next;
    logic [bytrun_pkg::PixW-1:0]          out_pix_reg, out_pix_next;
    logic [bytrun_pkg::CntW-1:0]          out_cnt_reg, out_cnt_next;
    logic                                 out_row_end_reg, out_row_end_next;
    logic                                 out_img_end_reg, out_img_end_next;
    logic [bytrun_pkg::WidthW-1:0]        out_width_reg, out_width_next;
    logic                                 out_last_reg, out_last_next;

    // RAM ports.
    logic                                 row_we;
    logic [7:0]                           row_wdata;
    logic [7:0]                           row_rdata;
    logic                                 acc_we;
    logic [bytrun_pkg::PixW-1:0]          acc_wdata;
    logic [bytrun_pkg::PixW-1:0]          acc_rdata;
    logic [AddrW-1:0]                     col_addr;

    // Decode helpers.
    logic                                 in_fire;
    logic                                 out_free;
    logic [bytrun_pkg::ColCntW-1:0]       wb;
    logic [10:0]                          width_round;
    logic [7:0]                           in_byte;
    logic [15:0]                          hv;
    logic [3:0]                           hpos;
    phase_t                               eff_phase;
    logic [bytrun_pkg::ColCntW-1:0]       col_inc;
    logic                                 last_plane;
    logic                                 last_row;
    logic                                 last_col;
    logic [7:0]                           plane_byte;
    logic [bytrun_pkg::PixW-1:0]          merged;
    logic [bytrun_pkg::WidthW-1:0]        rem;
    logic [bytrun_pkg::CntW-1:0]          cnt;
    logic [8:0]                           run_len;

    assign col_addr    = col_reg[AddrW-1:0];
    assign width_round = {1'b0, width_reg} + 11'(bytrun_pkg::ColRound);
    assign wb          = width_round[9:3];
    assign in_byte     = stream.data_byte;
    assign in_fire     = stream.valid && stream.ready;
    assign out_free    = !out_valid_reg || result.ready;
    assign stream.ready = (state_reg == S_IDLE);

    // Merge-pass arithmetic on the column that was read last cycle.
    assign last_plane = ({1'b0, plane_reg} + 4'd1) >= plane_count_reg;
    assign last_row   = ({1'b0, row_reg} + 17'd1) >= {1'b0, height_reg};
    assign last_col   = (col_reg + 7'd1) >= wb;
    assign plane_byte = rd_valid_reg ? row_rdata : 8'd0;
    assign merged     = (plane_reg == 3'd0)
                        ? spread_plane(plane_byte, plane_reg)
                        : (acc_rdata | spread_plane(plane_byte, plane_reg));
    assign rem        = width_reg - {1'b0, col_reg[bytrun_pkg::ColW-1:0], 3'b000};
    assign cnt        = (rem > 10'd8) ? 4'd8 : rem[3:0];
    assign run_len    = bytrun_pkg::RunBase - {1'b0, in_byte};

    // Header view of the incoming byte.
    assign hpos      = stream.first_of_image ? 4'd0 : header_pos_reg;
    assign eff_phase = stream.first_of_image ? P_HEADER : phase_reg;
    assign hv        = {header_high_reg, in_byte};

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next       = state_reg;
        phase_next       = phase_reg;
        header_pos_next  = header_pos_reg;
        header_high_next = header_high_reg;
        width_next       = width_reg;
        height_next      = height_reg;
        plane_count_next = plane_count_reg;
        row_next         = row_reg;
        plane_next       = plane_reg;
        col_next         = col_reg;
        lit_left_next    = lit_left_reg;
        run_left_next    = run_left_reg;
        fill_byte_next   = fill_byte_reg;
        row_valid_next   = row_valid_reg;
        col_inc          = col_reg;

        out_valid_next   = out_valid_reg && !result.ready;
        out_status_next  = out_status_reg;
        out_row_next     = out_row_reg;
        out_col_next     = out_col_reg;
        out_pix_next     = out_pix_reg;
        out_cnt_next     = out_cnt_reg;
        out_row_end_next = out_row_end_reg;
        out_img_end_next = out_img_end_reg;
        out_width_next   = out_width_reg;
        out_last_next    = out_last_reg;

        row_we    = 1'b0;
        row_wdata = in_byte;
        acc_we    = 1'b0;
        acc_wdata = merged;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (stream.first_of_image)
                    begin
                        row_valid_next  = '0;
                        header_pos_next = 4'd0;
                        phase_next      = P_HEADER;
                    end
                    case (eff_phase)
                        P_HEADER:
                        begin
                            header_pos_next = hpos + 4'd1;
                            case (hpos)
                                4'd0, 4'd2, 4'd4:
                                begin
                                    header_high_next = in_byte;
                                end
                                bytrun_pkg::HposWidthLo:
                                begin
                                    if (hv > 16'(MAX_WIDTH))
                                    begin
                                        phase_next = P_ERROR;
                                        state_next = S_ERR;
                                    end
                                    else
                                    begin
                                        width_next = hv[bytrun_pkg::WidthW-1:0];
                                    end
                                end
                                bytrun_pkg::HposHeightLo:
                                begin
                                    height_next = hv;
                                end
                                bytrun_pkg::HposDepthLo:
                                begin
                                    if (hv == 16'd0 || hv > 16'(bytrun_pkg::MaxPlanes))
                                    begin
                                        phase_next = P_ERROR;
                                        state_next = S_ERR;
                                    end
                                    else
                                    begin
                                        plane_count_next = hv[3:0];
                                    end
                                end
                                default:
                                begin
                                end
                            endcase
                            if (hpos >= bytrun_pkg::HeaderLast)
                            begin
                                row_next   = '0;
                                plane_next = '0;
                                col_next   = '0;
                                phase_next = (width_reg == '0 || height_reg == '0)
                                             ? P_DONE : P_CONTROL;
                            end
                        end
                        P_CONTROL:
                        begin
                            if (in_byte > bytrun_pkg::CtlRowEnd)
                            begin
                                run_left_next = run_len[7:0];
                                phase_next    = P_RUN;
                            end
                            else if (in_byte == bytrun_pkg::CtlRowEnd)
                            begin
                                col_next   = '0;
                                state_next = S_MERGE_RD;
                            end
                            else
                            begin
                                lit_left_next = in_byte + 8'd1;
                                phase_next    = P_LITERAL;
                            end
                        end
                        P_LITERAL:
                        begin
                            if (col_reg < wb)
                            begin
                                row_we                  = 1'b1;
                                row_valid_next[col_addr] = 1'b1;
                                col_inc                 = col_reg + 7'd1;
                            end
                            col_next      = col_inc;
                            lit_left_next = lit_left_reg - 8'd1;
                            if (lit_left_reg == 8'd1)
                            begin
                                phase_next = P_CONTROL;
                                if (col_inc >= wb)
                                begin
                                    col_next   = '0;
                                    state_next = S_MERGE_RD;
                                end
                            end
                        end
                        // The byte after a run control is repeated by the fill.
                        P_RUN:
                        begin
                            fill_byte_next = in_byte;
                            phase_next     = P_CONTROL;
                            state_next     = S_FILL;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            // One column of a run per cycle, clipped at the row end.
            S_FILL:
            begin
                row_we                   = 1'b1;
                row_wdata                = fill_byte_reg;
                row_valid_next[col_addr] = 1'b1;
                col_next                 = col_reg + 7'd1;
                run_left_next            = run_left_reg - 8'd1;
                if (last_col)
                begin
                    col_next   = '0;
                    state_next = S_MERGE_RD;
                end
                else if (run_left_reg == 8'd1)
                begin
                    state_next = S_IDLE;
                end
            end

            // Wait for the registered reads of this column.
            S_MERGE_RD:
            begin
                state_next = S_MERGE_OP;
            end

            // Merge the plane byte into the accumulator or emit the pixel group.
            S_MERGE_OP:
            begin
                if (!last_plane || out_free)
                begin
                    if (!last_plane)
                    begin
                        acc_we = 1'b1;
                    end
                    else
                    begin
                        out_valid_next   = 1'b1;
                        out_status_next  = 1'b0;
                        out_row_next     = row_reg;
                        out_col_next     = col_reg[bytrun_pkg::ColW-1:0];
                        out_pix_next     = merged & pixel_mask(cnt);
                        out_cnt_next     = cnt;
                        out_row_end_next = last_col;
                        out_img_end_next = last_col && last_row;
                        out_width_next   = width_reg;
                        out_last_next    = last_col;
                    end
                    if (last_col)
                    begin
                        col_next   = '0;
                        state_next = S_IDLE;
                        if (last_plane)
                        begin
                            plane_next = '0;
                            row_next   = row_reg + 16'd1;
                            phase_next = last_row ? P_DONE : P_CONTROL;
                        end
                        else
                        begin
                            plane_next = plane_reg + 3'd1;
                            phase_next = P_CONTROL;
                        end
                    end
                    else
                    begin
                        col_next   = col_reg + 7'd1;
                        state_next = S_MERGE_RD;
                    end
                end
            end

            // Single error beat for a rejected header.
            S_ERR:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_status_next  = 1'b1;
                    out_row_next     = '0;
                    out_col_next     = '0;
                    out_pix_next     = '0;
                    out_cnt_next     = '0;
                    out_row_end_next = 1'b0;
                    out_img_end_next = 1'b0;
                    out_width_next   = '0;
                    out_last_next    = 1'b1;
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            phase_reg       <= P_HEADER;
            header_pos_reg  <= '0;
            header_high_reg <= '0;
            width_reg       <= '0;
            height_reg      <= '0;
            plane_count_reg <= '0;
            row_reg         <= '0;
            plane_reg       <= '0;
            col_reg         <= '0;
            lit_left_reg    <= '0;
            run_left_reg    <= '0;
            fill_byte_reg   <= '0;
            row_valid_reg   <= '0;
            rd_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_status_reg  <= 1'b0;
            out_row_reg     <= '0;
            out_col_reg     <= '0;
            out_pix_reg     <= '0;
            out_cnt_reg     <= '0;
            out_row_end_reg <= 1'b0;
            out_img_end_reg <= 1'b0;
            out_width_reg   <= '0;
            out_last_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            phase_reg       <= phase_next;
            header_pos_reg  <= header_pos_next;
            header_high_reg <= header_high_next;
            width_reg       <= width_next;
            height_reg      <= height_next;
            plane_count_reg <= plane_count_next;
            row_reg         <= row_next;
            plane_reg       <= plane_next;
            col_reg         <= col_next;
            lit_left_reg    <= lit_left_next;
            run_left_reg    <= run_left_next;
            fill_byte_reg   <= fill_byte_next;
            row_valid_reg   <= row_valid_next;
            rd_valid_reg    <= row_valid_reg[col_addr];
            out_valid_reg   <= out_valid_next;
            out_status_reg  <= out_status_next;
            out_row_reg     <= out_row_next;
            out_col_reg     <= out_col_next;
            out_pix_reg     <= out_pix_next;
            out_cnt_reg     <= out_cnt_next;
            out_row_end_reg <= out_row_end_next;
            out_img_end_reg <= out_img_end_next;
            out_width_reg   <= out_width_next;
            out_last_reg    <= out_last_next;
        end
    end

    // Plane bytes of the current row.
    bytrun_ram #(
        .Width (8),
        .Depth (Cols)
    ) u_row_ram (
        .clk   (clk),
        .we    (row_we),
        .waddr (col_addr),
        .wdata (row_wdata),
        .raddr (col_addr),
        .rdata (row_rdata)
    );

    // Chunky accumulator, one pixel group per byte column.
    bytrun_ram #(
        .Width (bytrun_pkg::PixW),
        .Depth (Cols)
    ) u_acc_ram (
        .clk   (clk),
        .we    (acc_we),
        .waddr (col_addr),
        .wdata (acc_wdata),
        .raddr (col_addr),
        .rdata (acc_rdata)
    );

    // Result channel.
    assign result.valid       = out_valid_reg;
    assign result.status      = out_status_reg;
    assign result.row_index   = out_row_reg;
    assign result.byte_column = out_col_reg;
    assign result.pixels      = out_pix_reg;
    assign result.pixel_count = out_cnt_reg;
    assign result.row_end     = out_row_end_reg;
    assign result.image_end   = out_img_end_reg;
    assign result.image_width = out_width_reg;
    assign result.last        = out_last_reg;

    // Waiting for a control byte means the plane row still has room.
    `ASSERT_IMPLIES(a_ctrl_col_room, state_reg == S_IDLE && phase_reg == P_CONTROL,
        col_reg < wb, "control phase with the plane row already full")

    // Plane counter stays below the parsed depth while a row is decoded.
    `ASSERT_IMPLIES(a_plane_bound,
        phase_reg == P_CONTROL || phase_reg == P_LITERAL,
        plane_reg < plane_count_reg, "plane counter beyond the image depth")

    // A run fill always has columns left to write.
    `ASSERT_IMPLIES(a_fill_left, state_reg == S_FILL, run_left_reg != 8'd0,
        "run fill with no repeat count left")

    // The last repeat of a run ends the fill.
    `ASSERT_NEXT(a_fill_ends, state_reg == S_FILL && run_left_reg == 8'd1,
        state_reg != S_FILL, "run fill did not stop at its last repeat")

endmodule

### tb/tb_byterun1_planar_to_chunky_decoder_core.sv
// Self-checking testbench of the ByteRun1 planar-to-chunky decoder core with its scoreboard.

// One result beat as it leaves the decoder.
typedef struct packed {
    logic                              status;
    logic [bytrun_pkg::RowW-1:0]       row_index;
    logic [bytrun_pkg::ColW-1:0]       byte_column;
    logic [bytrun_pkg::PixW-1:0]       pixels;
    logic [bytrun_pkg::CntW-1:0]       pixel_count;
    logic                              row_end;
    logic                              image_end;
    logic [bytrun_pkg::WidthW-1:0]     image_width;
    logic                              last;
} pix_beat_t;

typedef enum logic [2:0] {
    DEC_HEADER,
    DEC_CONTROL,
    DEC_LITERAL,
    DEC_RUN,
    DEC_DONE,
    DEC_ERROR
} decode_phase_t;

// Tracks the decoder state byte by byte and holds the pixel groups still owed.
class chunky_row_scoreboard;
    pix_beat_t                         pending_groups[$];
    int                                mismatch_count;
    int                                working_bytes;

    decode_phase_t                     phase;
    logic [3:0]                        hdr_pos;
    logic [7:0]                        hdr_high;
    logic [bytrun_pkg::WidthW-1:0]     img_width;
    logic [bytrun_pkg::RowW-1:0]       img_height;
    logic [3:0]                        plane_total;
    logic [bytrun_pkg::RowW-1:0]       row;
    logic [2:0]                        plane;
    logic [7:0]                        col;
    logic [7:0]                        lit_left;
    logic [7:0]                        run_len;
    logic [7:0]                        plane_row[64];
    logic [bytrun_pkg::PixW-1:0]       accum[64];

    function new();
        phase       = DEC_HEADER;
        hdr_pos     = '0;
        hdr_high    = '0;
        img_width   = '0;
        img_height  = '0;
        plane_total = '0;
        row         = '0;
        plane       = '0;
        col         = '0;
        lit_left    = '0;
        run_len     = '0;
        for (int c = 0; c < 64; c++)
        begin
            plane_row[c] = '0;
            accum[c]     = '0;
        end
        mismatch_count = 0;
        working_bytes  = 0;
    endfunction

    function int row_bytes();
        return (int'(img_width) + bytrun_pkg::ColRound) >> 3;
    endfunction

    task report_mismatch(input string msg);
        if (mismatch_count < 100)
            $display("[%0t] MISMATCH: %s", $time, msg);
        mismatch_count++;
    endtask

    // A rejected header gives one beat with only status and last set.
    function void reject_header();
        pix_beat_t beat;
        beat        = '0;
        beat.status = 1'b1;
        beat.last   = 1'b1;
        pending_groups.push_back(beat);
        phase = DEC_ERROR;
    endfunction

    // Merge the finished plane row into the accumulator; emit the row after its last plane.
    function void close_plane_row();
        int                          wb;
        int                          cnt;
        bit                          last_plane;
        bit                          last_row;
        logic [bytrun_pkg::PixW-1:0] bits;
        logic [bytrun_pkg::PixW-1:0] mask;
        pix_beat_t                   beat;
        wb         = row_bytes();
        last_plane = (int'(plane) + 1) >= int'(plane_total);
        last_row   = (int'(row) + 1) >= int'(img_height);
        for (int c = 0; c < wb; c++)
        begin
            bits = '0;
            for (int i = 0; i < 8; i++)
                if (plane_row[c][7-i])
                    bits[56 - 8*i + int'(plane)] = 1'b1;
            accum[c] = (plane == 0) ? bits : (accum[c] | bits);
        end
        if (last_plane)
        begin
            for (int c = 0; c < wb; c++)
            begin
                cnt = int'(img_width) - 8*c;
                if (cnt > 8)
                    cnt = 8;
                mask = '1;
                if (cnt < 8)
                    mask = mask << (64 - 8*cnt);
                beat             = '0;
                beat.row_index   = row;
                beat.byte_column = 6'(c);
                beat.pixels      = accum[c] & mask;
                beat.pixel_count = 4'(cnt);
                beat.row_end     = (c + 1 == wb);
                beat.image_end   = (c + 1 == wb) && last_row;
                beat.image_width = img_width;
                beat.last        = (c + 1 == wb);
                pending_groups.push_back(beat);
            end
            plane = '0;
            row   = row + 1'b1;
            phase = last_row ? DEC_DONE : DEC_CONTROL;
        end
        else
        begin
            plane = plane + 1'b1;
            phase = DEC_CONTROL;
        end
        col = '0;
    endfunction

    // Advance the decoder state by one accepted input beat.
    function void note_byte(input logic [7:0] b, input logic first);
        logic [15:0] v;
        logic [3:0]  pos;
        int          wb;
        int          rep;
        if (first)
        begin
            for (int c = 0; c < 64; c++)
                plane_row[c] = '0;
            hdr_pos = '0;
            phase   = DEC_HEADER;
        end
        if (phase != DEC_DONE && phase != DEC_ERROR)
            working_bytes++;
        wb = row_bytes();
        case (phase)
            DEC_HEADER:
            begin
                pos = hdr_pos;
                v   = {hdr_high, b};
                if (pos == bytrun_pkg::HposWidthLo)
                begin
                    if (v > bytrun_pkg::MaxWidthDef)
                    begin
                        reject_header();
                        return;
                    end
                    img_width = v[bytrun_pkg::WidthW-1:0];
                end
                else if (pos == bytrun_pkg::HposHeightLo)
                    img_height = v;
                else if (pos == bytrun_pkg::HposDepthLo)
                begin
                    if (v == 0 || v > bytrun_pkg::MaxPlanes)
                    begin
                        reject_header();
                        return;
                    end
                    plane_total = v[3:0];
                end
                else if (pos < bytrun_pkg::HposDepthLo)
                    hdr_high = b;
                hdr_pos = pos + 1'b1;
                if (pos >= bytrun_pkg::HeaderLast)
                begin
                    row   = '0;
                    plane = '0;
                    col   = '0;
                    phase = (img_width == 0 || img_height == 0) ? DEC_DONE : DEC_CONTROL;
                end
            end
            DEC_CONTROL:
            begin
                if (b > bytrun_pkg::CtlRowEnd)
                begin
                    run_len = 8'(bytrun_pkg::RunBase - {1'b0, b});
                    phase   = DEC_RUN;
                end
                else if (b == bytrun_pkg::CtlRowEnd)
                    close_plane_row();
                else
                begin
                    lit_left = b + 8'd1;
                    phase    = DEC_LITERAL;
                end
            end
            DEC_LITERAL:
            begin
                if (int'(col) < wb)
                begin
                    plane_row[col[5:0]] = b;
                    col = col + 1'b1;
                end
                if (lit_left > 0)
                    lit_left = lit_left - 1'b1;
                if (lit_left == 0)
                begin
                    if (int'(col) >= wb)
                        close_plane_row();
                    else
                        phase = DEC_CONTROL;
                end
            end
            DEC_RUN:
            begin
                rep = int'(run_len);
                if (int'(col) + rep > wb)
                    rep = wb - int'(col);
                for (int k = 0; k < rep; k++)
                    plane_row[(int'(col) + k) & 63] = b;
                col   = 8'(int'(col) + rep);
                phase = DEC_CONTROL;
                if (int'(col) >= wb)
                    close_plane_row();
            end
            default:
            begin
            end
        endcase
    endfunction

    task check_field(input string name, input logic [63:0] got_v, input logic [63:0] want_v,
                     input pix_beat_t want);
        if (got_v !== want_v)
            report_mismatch($sformatf("row %0d column %0d %s: got %h, want %h",
                                      want.row_index, want.byte_column, name, got_v, want_v));
    endtask

    // Compare one accepted result beat with the oldest group owed.
    task check_result(input pix_beat_t got);
        pix_beat_t want;
        if (pending_groups.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result beat, row %0d column %0d status %b",
                                      got.row_index, got.byte_column, got.status));
            return;
        end
        want = pending_groups.pop_front();
        check_field("status", got.status, want.status, want);
        check_field("row_index", got.row_index, want.row_index, want);
        check_field("byte_column", got.byte_column, want.byte_column, want);
        check_field("pixels", got.pixels, want.pixels, want);
        check_field("pixel_count", got.pixel_count, want.pixel_count, want);
        check_field("row_end", got.row_end, want.row_end, want);
        check_field("image_end", got.image_end, want.image_end, want);
        check_field("image_width", got.image_width, want.image_width, want);
        check_field("last", got.last, want.last, want);
    endtask
endclass

module tb_byterun1_planar_to_chunky_decoder_core;
    timeunit 1ns;
    timeprecision 1ps;

    logic clk;
    logic rst_n;

    bytrun_in_if  stream_if ();
    bytrun_out_if result_if ();

    chunky_row_scoreboard sb;

    int tx_idle_pct;
    int rx_idle_pct;
    int rx_hold_cycles;

    byterun1_planar_to_chunky_decoder_core DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream_if),
        .result (result_if)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard limit on the run time.
    initial
    begin
        #8_000_000;
        $display("Verification failed");
        $finish;
    end

    // Receiver: random stalls, plus a long hold-off counted down here when requested.
    initial
    begin
        result_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_cycles > 0)
            begin
                result_if.ready <= 1'b0;
                rx_hold_cycles = rx_hold_cycles - 1;
            end
            else
                result_if.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Monitor: check result beats first, since they come from bytes taken earlier.
    always @(posedge clk)
    begin : monitor
        pix_beat_t seen;
        if (rst_n)
        begin
            if (result_if.valid && result_if.ready)
            begin
                seen.status      = result_if.status;
                seen.row_index   = result_if.row_index;
                seen.byte_column = result_if.byte_column;
                seen.pixels      = result_if.pixels;
                seen.pixel_count = result_if.pixel_count;
                seen.row_end     = result_if.row_end;
                seen.image_end   = result_if.image_end;
                seen.image_width = result_if.image_width;
                seen.last        = result_if.last;
                sb.check_result(seen);
            end
            if (stream_if.valid && stream_if.ready)
                sb.note_byte(stream_if.data_byte, stream_if.first_of_image);
        end
    end

    // Offer one byte, with random idle cycles ahead of it, and return once it is taken.
    task automatic send_byte(input logic [7:0] d, input logic f);
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            stream_if.valid <= 1'b0;
            @(negedge clk);
        end
        stream_if.valid          <= 1'b1;
        stream_if.data_byte      <= d;
        stream_if.first_of_image <= f;
        @(posedge clk);
        while (!stream_if.ready)
            @(posedge clk);
    endtask

    // Hold the input idle until every owed group has come out.
    task automatic wait_drained();
        @(negedge clk);
        stream_if.valid <= 1'b0;
        while (sb.pending_groups.size() != 0)
            @(negedge clk);
    endtask

    task automatic send_noise(input int n, input bit allow_restart);
        repeat (n)
            send_byte(8'($urandom), allow_restart && ($urandom_range(15) == 0));
    endtask

    // Header: big-endian width, height and depth, then six filler bytes.
    task automatic send_header(input int w, input int h, input int d, input logic f);
        logic [15:0] wv;
        logic [15:0] hv;
        logic [15:0] dv;
        wv = 16'(w);
        hv = 16'(h);
        dv = 16'(d);
        send_byte(wv[15:8], f);
        send_byte(wv[7:0], 1'b0);
        send_byte(hv[15:8], 1'b0);
        send_byte(hv[7:0], 1'b0);
        send_byte(dv[15:8], 1'b0);
        send_byte(dv[7:0], 1'b0);
        send_noise(6, 1'b0);
    endtask

    // One plane row as a random mix of literals, runs and early ends,
    // sometimes running past the row end.
    task automatic send_plane_row(input int wb);
        int col;
        int room;
        int len;
        int pick;
        col = 0;
        while (col < wb)
        begin
            room = wb - col;
            pick = $urandom_range(99);
            len  = $urandom_range(1, (room > 128) ? 128 : room);
            if ($urandom_range(7) == 0)
                len = len + $urandom_range(1, 3);
            if (len > 128)
                len = 128;
            if (pick < 6)
            begin
                send_byte(bytrun_pkg::CtlRowEnd, 1'b0);
                col = wb;
            end
            else if (pick < 45)
            begin
                if (len < 2)
                    len = 2;
                send_byte(8'(bytrun_pkg::RunBase - 9'(len)), 1'b0);
                send_byte(8'($urandom), 1'b0);
                col = col + len;
            end
            else
            begin
                send_byte(8'(len - 1), 1'b0);
                repeat (len)
                    send_byte(8'($urandom), 1'b0);
                col = col + len;
            end
        end
    endtask

    // Header followed by up to keep plane rows of the image.
    task automatic send_image(input int w, input int h, input int d, input logic f,
                              input int keep);
        send_header(w, h, d, f);
        if (w > 0 && h > 0)
            for (int n = 0; n < keep && n < h * d; n++)
                send_plane_row((w + bytrun_pkg::ColRound) / 8);
    endtask

    // Stimulus.
    initial
    begin
        int rand_goal;
        int pick;
        int w;
        int h;
        int d;

        sb                       = new();
        tx_idle_pct              = 26;
        rx_idle_pct              = 26;
        rx_hold_cycles           = 0;
        rst_n                    = 1'b0;
        stream_if.valid          = 1'b0;
        stream_if.data_byte      = '0;
        stream_if.first_of_image = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // First image straight after reset, without the restart flag.
        send_header(8, 1, 1, 1'b0);
        send_byte(8'd0, 1'b0);
        send_byte(8'($urandom), 1'b0);

        // Shortest run, then the longest run clipped at the row end.
        send_header(16, 1, 2, 1'b1);
        send_byte(8'd255, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'd129, 1'b0);
        send_byte(8'h00, 1'b0);

        // Longest literal, most of it past the row end.
        send_header(16, 1, 1, 1'b1);
        send_byte(8'd127, 1'b0);
        send_noise(128, 1'b0);

        // Early ends that leave stale bytes from earlier plane rows.
        send_header(24, 2, 2, 1'b1);
        send_byte(8'd2, 1'b0);
        send_noise(3, 1'b0);
        send_byte(bytrun_pkg::CtlRowEnd, 1'b0);
        send_byte(bytrun_pkg::CtlRowEnd, 1'b0);
        send_byte(8'd0, 1'b0);
        send_byte(8'($urandom), 1'b0);
        send_byte(bytrun_pkg::CtlRowEnd, 1'b0);

        // One-pixel rows with every plane.
        send_image(1, 2, bytrun_pkg::MaxPlanes, 1'b1, 16);

        // Widest rows while the receiver holds off, so the decoder backs up.
        send_header(bytrun_pkg::MaxWidthDef, 2, 1, 1'b1);
        rx_hold_cycles = 400;
        send_plane_row(64);
        send_plane_row(64);
        wait_drained();

        // Rejected headers, each followed by bytes that must be ignored.
        send_header(bytrun_pkg::MaxWidthDef + 1, 1, 1, 1'b1);
        send_noise(3, 1'b0);
        send_header(16'hFFFF, 1, 1, 1'b1);
        send_header(8, 1, 0, 1'b1);
        send_header(8, 1, bytrun_pkg::MaxPlanes + 1, 1'b1);
        send_header(8, 1, 16'h0101, 1'b1);
        send_noise(2, 1'b0);

        // Empty images, then bytes after the image.
        send_header(0, 4, 3, 1'b1);
        send_noise(3, 1'b0);
        send_header(8, 0, 1, 1'b1);
        send_noise(2, 1'b0);

        // Restart in the middle of a header and in the middle of an image.
        send_byte(8'd0, 1'b1);
        send_byte(8'd8, 1'b0);
        send_byte(8'd0, 1'b0);
        send_image(8, 1, 1, 1'b1, 1);
        send_image(16, 2, 2, 1'b1, 1);
        send_image(9, 1, 3, 1'b1, 3);
        send_noise(4, 1'b0);
        wait_drained();

        // Random images; the first stretch runs without any idling.
        rand_goal   = sb.working_bytes + 310;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        while (sb.working_bytes < rand_goal)
        begin
            if (sb.working_bytes > rand_goal - 210)
            begin
                tx_idle_pct = 26;
                rx_idle_pct = 26;
            end
            pick = $urandom_range(99);
            w    = $urandom_range(99);
            if (w < 4)
                w = $urandom_range(400, bytrun_pkg::MaxWidthDef);
            else if (w < 20)
                w = 8 * $urandom_range(1, 6);
            else
                w = $urandom_range(1, 40);
            h = (w > 256) ? 1 : $urandom_range(1, 3);
            d = $urandom_range(1) ? $urandom_range(1, 2)
                                  : $urandom_range(1, bytrun_pkg::MaxPlanes);
            if (pick < 55)
                send_image(w, h, d, 1'b1, h * d);
            else if (pick < 65)
            begin
                if ($urandom_range(1))
                    send_header($urandom_range(bytrun_pkg::MaxWidthDef + 1, 65535),
                                1, 1, 1'b1);
                else
                    send_header(w, 1, $urandom_range(1) ? 0 :
                                $urandom_range(bytrun_pkg::MaxPlanes + 1, 65535), 1'b1);
                send_noise(3, 1'b0);
            end
            else if (pick < 73)
            begin
                if ($urandom_range(1))
                    send_header(0, $urandom_range(0, 5), d, 1'b1);
                else
                    send_header(w, 0, d, 1'b1);
                send_noise(2, 1'b0);
            end
            else if (pick < 88)
            begin
                send_image(w, h, d, 1'b1, $urandom_range(0, h * d - 1));
                send_noise($urandom_range(0, 3), 1'b0);
            end
            else if (pick < 95)
                send_noise($urandom_range(1, 12), 1'b1);
            else
                wait_drained();
        end

        // Drain, then give the decoder time to show any stray beat.
        wait_drained();
        repeat (300) @(negedge clk);
        if (sb.pending_groups.size() != 0)
            sb.report_mismatch($sformatf("%0d result beats never arrived",
                                         sb.pending_groups.size()));
        if (sb.mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
